// File: rtl/vvtp_pkg.sv
// Shared types, constants and register codes for the vertex view transform block.
`timescale 1ns / 1ps
package vvtp_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int MID_DEPTH_D = 4;
  localparam int OUT_DEPTH_D = 2;

  localparam logic signed [15:0] PROJ_SCALE   = 16'sd100;
  localparam logic signed [15:0] SCREEN_MID_X = 16'sd160;
  localparam logic signed [15:0] SCREEN_MID_Y = 16'sd100;
  localparam logic signed [15:0] OFF_SCREEN   = -16'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_AZIMUTH   = 3'd0,
    CFG_SIN_AZIMUTH   = 3'd1,
    CFG_COS_ELEVATION = 3'd2,
    CFG_SIN_ELEVATION = 3'd3,
    CFG_VIEW_DISTANCE = 3'd4,
    CFG_COS_ROLL      = 3'd5,
    CFG_SIN_ROLL      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] cos_azimuth;
    logic signed [15:0] sin_azimuth;
    logic signed [15:0] cos_elevation;
    logic signed [15:0] sin_elevation;
    logic signed [23:0] view_distance;
    logic signed [15:0] cos_roll;
    logic signed [15:0] sin_roll;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic signed [23:0] vertex_z;
    logic               last_vertex;
  } in_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [23:0] view_x;
    logic signed [23:0] view_y;
    logic signed [23:0] view_z;
    logic               last_out;
  } out_t;

  // Observer-space point handed from the front to the back.
  typedef struct packed {
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
    logic               last;
  } view_t;

endpackage

// File: rtl/vvtp_fifo.sv
// Small register queue used between the stages and at the result side.
`timescale 1ns / 1ps
module vvtp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end
endmodule

// File: rtl/vvtp_front.sv
// Front pipeline: rotate a model vertex into observer space and round/saturate it.
`timescale 1ns / 1ps
module vvtp_front import vvtp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_push,
  input  in_t   in_data,
  output logic  in_full,
  output logic  q_push,
  output view_t q_data,
  input  logic  q_full
);
  localparam int SW = 59;
  localparam logic signed [23:0] V_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] V_MIN = 24'sh800000;

  logic en;
  logic s0_v_r, s1_v_r, s2_v_r, s3_v_r;

  logic signed [31:0] cc_r, sc_r, cs_r, ss_r;
  in_t                s0_r;
  logic signed [55:0] p_xcc_r, p_ysc_r, p_xcs_r, p_yss_r;
  logic signed [39:0] p_zse_r, p_zce_r, p_xsa_r, p_yca_r;
  logic               s1_last_r, s2_last_r;
  logic signed [SW-1:0] zf_r, yf_r, xf_r;
  logic signed [SW-1:0] zf_nxt, yf_nxt, xf_nxt;
  view_t              s3_r;

  function automatic logic signed [23:0] sat24(input logic signed [SW-1:0] v);
    if (v > SW'(V_MAX)) return V_MAX;
    if (v < SW'(V_MIN)) return V_MIN;
    return $signed(v[23:0]);
  endfunction

  // Advance when the last stage is empty or the queue has room.
  assign en      = !s3_v_r || !q_full;
  assign in_full = !en;
  assign q_push  = s3_v_r && en;
  assign q_data  = s3_r;

  always_comb begin
    zf_nxt = -SW'(p_xcc_r) - SW'(p_ysc_r) - (SW'(p_zse_r) <<< 14)
             + (SW'(cfg.view_distance) <<< 28);
    yf_nxt = -SW'(p_xcs_r) - SW'(p_yss_r) + (SW'(p_zce_r) <<< 14);
    xf_nxt = -SW'(p_xsa_r) + SW'(p_yca_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_push;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Trig products follow the registers; the user must change them only while idle, and the block does not enforce it.
  always_ff @(posedge clk) begin
    cc_r <= cfg.cos_azimuth * cfg.cos_elevation;
    sc_r <= cfg.sin_azimuth * cfg.cos_elevation;
    cs_r <= cfg.cos_azimuth * cfg.sin_elevation;
    ss_r <= cfg.sin_azimuth * cfg.sin_elevation;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r      <= in_data;
      p_xcc_r   <= s0_r.vertex_x * cc_r;
      p_ysc_r   <= s0_r.vertex_y * sc_r;
      p_xcs_r   <= s0_r.vertex_x * cs_r;
      p_yss_r   <= s0_r.vertex_y * ss_r;
      p_zse_r   <= s0_r.vertex_z * cfg.sin_elevation;
      p_zce_r   <= s0_r.vertex_z * cfg.cos_elevation;
      p_xsa_r   <= s0_r.vertex_x * cfg.sin_azimuth;
      p_yca_r   <= s0_r.vertex_y * cfg.cos_azimuth;
      s1_last_r <= s0_r.last_vertex;
      zf_r      <= zf_nxt;
      yf_r      <= yf_nxt;
      xf_r      <= xf_nxt;
      s2_last_r <= s1_last_r;
      // Round to nearest, ties up, then clamp.
      s3_r.vz   <= sat24((zf_r + (SW'(1) <<< 27)) >>> 28);
      s3_r.vy   <= sat24((yf_r + (SW'(1) <<< 27)) >>> 28);
      s3_r.vx   <= sat24((xf_r + (SW'(1) <<< 13)) >>> 14);
      s3_r.last <= s2_last_r;
    end
  end
endmodule

// File: rtl/vvtp_back.sv
// Back pipeline: roll rotation, pipelined divide by depth and screen offset.
`timescale 1ns / 1ps
module vvtp_back import vvtp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_empty,
  input  view_t q_data,
  output logic  q_pop,
  output logic  r_push,
  output out_t  r_data,
  input  logic  r_full
);
  localparam int QW = 34;
  localparam int DW = 23;
  localparam int XW = QW + 2;

  typedef struct packed {
    logic [QW-1:0] num;
    logic [QW-1:0] quo;
    logic [DW-1:0] rem;
    logic          neg;
  } lane_t;

  typedef struct packed {
    view_t pt;
    logic  vis;
  } carry_t;

  logic en;
  logic b0_v_r, b1_v_r, b2_v_r, fin_v_r;
  logic dv_v_r [QW];

  carry_t b0_r, b1_r, b2_r, fin_r;
  carry_t dc_r [QW];
  lane_t  dx_r [QW], dy_r [QW];
  lane_t  dx_nxt [QW], dy_nxt [QW];
  lane_t  b2x_r, b2y_r;

  logic signed [39:0] m_cx_r, m_sy_r, m_sx_r, m_cy_r;
  logic signed [40:0] ax_r, ay_r;
  logic signed [15:0] sx_r, sy_r;

  function automatic lane_t div_step(input lane_t l, input logic [DW-1:0] d);
    lane_t       o;
    logic [DW:0] rs;
    logic [DW+1:0] tr;
    o   = l;
    rs  = {l.rem, l.num[QW-1]};
    tr  = {1'b0, rs} - {2'b00, d};
    o.num = l.num << 1;
    if (!tr[DW+1]) begin
      o.rem = tr[DW-1:0];
      o.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = rs[DW-1:0];
      o.quo = {l.quo[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic lane_t lane_init(input logic signed [40:0] a);
    lane_t       o;
    logic [40:0] mag;
    logic [47:0] n;
    mag   = a[40] ? 41'(-a) : 41'(a);
    n     = 48'(mag) * 48'(PROJ_SCALE);
    o.num = n[QW+13:14];
    o.quo = '0;
    o.rem = '0;
    o.neg = a[40];
    return o;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [XW-1:0] v);
    if (v > XW'(16'sh7FFF)) return 16'sh7FFF;
    if (v < XW'(16'sh8000)) return 16'sh8000;
    return $signed(v[15:0]);
  endfunction

  function automatic logic signed [XW-1:0] signed_q(input lane_t l);
    logic signed [XW-1:0] q;
    q = $signed(XW'(l.quo));
    return l.neg ? -q : q;
  endfunction

  assign en     = !fin_v_r || !r_full;
  assign q_pop  = !q_empty && en;
  assign r_push = fin_v_r && en;

  always_comb begin
    dx_nxt[0] = div_step(b2x_r, b2_r.pt.vz[DW-1:0]);
    dy_nxt[0] = div_step(b2y_r, b2_r.pt.vz[DW-1:0]);
    for (int k = 1; k < QW; k++) begin
      dx_nxt[k] = div_step(dx_r[k-1], dc_r[k-1].pt.vz[DW-1:0]);
      dy_nxt[k] = div_step(dy_r[k-1], dc_r[k-1].pt.vz[DW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r  <= 1'b0;
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
      for (int k = 0; k < QW; k++) dv_v_r[k] <= 1'b0;
    end else if (en) begin
      b0_v_r <= !q_empty;
      b1_v_r <= b0_v_r;
      b2_v_r <= b1_v_r;
      dv_v_r[0] <= b2_v_r;
      for (int k = 1; k < QW; k++) dv_v_r[k] <= dv_v_r[k-1];
      fin_v_r <= dv_v_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_r.pt  <= q_data;
      b0_r.vis <= !q_data.vz[23] && (q_data.vz != '0);
      m_cx_r   <= cfg.cos_roll * q_data.vx;
      m_sy_r   <= cfg.sin_roll * q_data.vy;
      m_sx_r   <= cfg.sin_roll * q_data.vx;
      m_cy_r   <= cfg.cos_roll * q_data.vy;
      b1_r     <= b0_r;
      ax_r     <= 41'(m_cx_r) - 41'(m_sy_r);
      ay_r     <= 41'(m_sx_r) + 41'(m_cy_r);
      b2_r     <= b1_r;
      // Scale by 100 and drop the Q14 fraction, aligned with b2_r.
      b2x_r    <= lane_init(ax_r);
      b2y_r    <= lane_init(ay_r);
      dc_r[0]  <= b2_r;
      for (int k = 1; k < QW; k++) dc_r[k] <= dc_r[k-1];
      for (int k = 0; k < QW; k++) begin
        dx_r[k] <= dx_nxt[k];
        dy_r[k] <= dy_nxt[k];
      end
      fin_r <= dc_r[QW-1];
      sx_r  <= sat16(XW'(SCREEN_MID_X) + signed_q(dx_r[QW-1]));
      sy_r  <= sat16(XW'(SCREEN_MID_Y) - signed_q(dy_r[QW-1]));
    end
  end

  always_comb begin
    r_data.visible  = fin_r.vis;
    r_data.screen_x = fin_r.vis ? sx_r : OFF_SCREEN;
    r_data.screen_y = fin_r.vis ? sy_r : OFF_SCREEN;
    r_data.view_x   = fin_r.pt.vx;
    r_data.view_y   = fin_r.pt.vy;
    r_data.view_z   = fin_r.pt.vz;
    r_data.last_out = fin_r.pt.last;
  end
endmodule

// File: rtl/vertex_view_transform_project.sv
// Top level of the vertex view transform and perspective projection block.
`timescale 1ns / 1ps
// Takes one model vertex per request (Q12.12) and returns one result per
// request: observer coordinates plus a projected, roll-rotated screen point.
// The block sustains one vertex per clock while results are taken. The front
// registers the input, then products, sums and round/clamp; the back has roll
// products, sums, scaling, a 34-stage restoring divider that retires one
// quotient bit per stage, and the screen offset. A 4-entry queue between
// front and back and a 2-entry result queue let each side stall on its own.
// The user must change configuration registers only while idle; the block
// does not enforce it. A write lands in the register file at the clock edge.
module vertex_view_transform_project import vvtp_pkg::*; #(
  parameter int MID_DEPTH = MID_DEPTH_D,
  parameter int OUT_DEPTH = OUT_DEPTH_D
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_t                   in_data,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  cfg_t  cfg_r;
  logic  mq_push, mq_full, mq_pop, mq_empty;
  view_t mq_din, mq_dout;
  logic  rq_push, rq_full;
  out_t  rq_din;

  // Register file: write at the edge, ignore unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_azimuth   <= 16'sd16384;
      cfg_r.sin_azimuth   <= 16'sd0;
      cfg_r.cos_elevation <= 16'sd16384;
      cfg_r.sin_elevation <= 16'sd0;
      cfg_r.view_distance <= 24'sd40960;
      cfg_r.cos_roll      <= 16'sd16384;
      cfg_r.sin_roll      <= 16'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COS_AZIMUTH:   cfg_r.cos_azimuth   <= $signed(cfg_wdata[15:0]);
        CFG_SIN_AZIMUTH:   cfg_r.sin_azimuth   <= $signed(cfg_wdata[15:0]);
        CFG_COS_ELEVATION: cfg_r.cos_elevation <= $signed(cfg_wdata[15:0]);
        CFG_SIN_ELEVATION: cfg_r.sin_elevation <= $signed(cfg_wdata[15:0]);
        CFG_VIEW_DISTANCE: cfg_r.view_distance <= $signed(cfg_wdata[23:0]);
        CFG_COS_ROLL:      cfg_r.cos_roll      <= $signed(cfg_wdata[15:0]);
        CFG_SIN_ROLL:      cfg_r.sin_roll      <= $signed(cfg_wdata[15:0]);
        default: ;
      endcase
    end
  end

  // Front: observer transform, pushes into the middle queue.
  vvtp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_push  (mq_push),
    .q_data  (mq_din),
    .q_full  (mq_full)
  );

  vvtp_fifo #(.W($bits(view_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .din   (mq_din),
    .full  (mq_full),
    .pop   (mq_pop),
    .dout  (mq_dout),
    .empty (mq_empty)
  );

  // Back: projection and divide, pushes finished results.
  vvtp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (mq_empty),
    .q_data  (mq_dout),
    .q_pop   (mq_pop),
    .r_push  (rq_push),
    .r_data  (rq_din),
    .r_full  (rq_full)
  );

  // Result queue: holds finished requests while the consumer stalls.
  vvtp_fifo #(.W($bits(out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .din   (rq_din),
    .full  (rq_full),
    .pop   (out_pop),
    .dout  (out_data),
    .empty (out_empty)
  );
endmodule

// File: rtl/vvtp_checker.sv
// Port-level checks for the vertex view transform block, bound to the top level.
`timescale 1ns / 1ps
module vvtp_checker import vvtp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_empty,
  input logic out_pop,
  input out_t out_data
);
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("results present right after reset");

  a_hidden_off_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.visible) |->
      (out_data.screen_x == OFF_SCREEN && out_data.screen_y == OFF_SCREEN))
    else $error("hidden point not at off-screen code");

  a_visible_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.visible) |->
      (!out_data.view_z[23] && out_data.view_z != '0))
    else $error("visible point with non-positive depth");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed");
endmodule

bind vertex_view_transform_project vvtp_checker u_vvtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
